[rtl/eulr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eulr_pkg
// types, cordic constants and helper functions for the euler rotation block
// ----------------------------------------------------------------------------
package eulr_pkg;

  localparam int CORDIC_ITERS    = 28;
  localparam int ITERS_PER_STAGE = 4;
  localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;

  typedef logic signed [33:0] cwide_t;
  typedef logic signed [31:0] coord_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [64:0] psum_t;
  typedef logic [1:0]         quad_t;

  localparam cwide_t GAIN_INV   = 34'sd652032874;
  localparam psum_t  ROUND_HALF = 65'sd536870912;
  localparam logic signed [34:0] COORD_MAX = 35'sd2147483647;
  localparam logic signed [34:0] COORD_MIN = -35'sd2147483648;

  typedef struct packed {
    cwide_t x;
    cwide_t y;
    coord_t z;
  } cordic_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t c;
    coord_t s;
  } trig_t;

  typedef struct packed {
    logic   sat;
    coord_t v;
  } mix_t;

  function automatic coord_t atan_val(input int i);
    coord_t r;
    case (i)
      0:  r = 32'sd536870912;
      1:  r = 32'sd316933406;
      2:  r = 32'sd167458907;
      3:  r = 32'sd85004756;
      4:  r = 32'sd42667331;
      5:  r = 32'sd21354465;
      6:  r = 32'sd10679838;
      7:  r = 32'sd5340245;
      8:  r = 32'sd2670163;
      9:  r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41722;
      15: r = 32'sd20861;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      18: r = 32'sd2608;
      19: r = 32'sd1304;
      20: r = 32'sd652;
      21: r = 32'sd326;
      22: r = 32'sd163;
      23: r = 32'sd81;
      24: r = 32'sd41;
      25: r = 32'sd20;
      26: r = 32'sd10;
      27: r = 32'sd5;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic cordic_t cordic_group(input cordic_t a, input int base);
    cordic_t t;
    cwide_t  nx;
    t = a;
    for (int k = 0; k < ITERS_PER_STAGE; k++) begin
      if (!t.z[31]) begin
        nx  = t.x - (t.y >>> (base + k));
        t.y = t.y + (t.x >>> (base + k));
        t.z = t.z - atan_val(base + k);
      end else begin
        nx  = t.x + (t.y >>> (base + k));
        t.y = t.y - (t.x >>> (base + k));
        t.z = t.z + atan_val(base + k);
      end
      t.x = nx;
    end
    return t;
  endfunction

  function automatic trig_t quad_map(input cordic_t a, input quad_t q);
    trig_t  r;
    coord_t cx;
    coord_t cy;
    cx = coord_t'(a.x);
    cy = coord_t'(a.y);
    case (q)
      2'd0:    begin r.c = cx;  r.s = cy;  end
      2'd1:    begin r.c = -cy; r.s = cx;  end
      2'd2:    begin r.c = -cx; r.s = -cy; end
      default: begin r.c = cy;  r.s = -cx; end
    endcase
    return r;
  endfunction

  function automatic mix_t round_sat(input psum_t a, input psum_t b);
    mix_t               r;
    psum_t              s;
    logic signed [34:0] v;
    s = a + b + ROUND_HALF;
    v = 35'(s >>> 30);
    r.sat = 1'b0;
    if (v > COORD_MAX) begin
      r.sat = 1'b1;
      r.v   = 32'sh7fffffff;
    end else if (v < COORD_MIN) begin
      r.sat = 1'b1;
      r.v   = 32'sh80000000;
    end else begin
      r.v = coord_t'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/euler_xyz_rotation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euler_xyz_rotation
// rotates a q16.16 point about z, then y, then x by three binary angles
// ----------------------------------------------------------------------------
// One item per cycle when not stalled. Angle setup takes one stage, three
// parallel 28-step cordic units take seven stages of four steps each, the
// quadrant fold one stage, and each of the three axis rotations two stages
// (a 32x32 multiply stage, then a round and saturate stage). The whole pipe
// advances together and holds while the result register is stalled.
module euler_xyz_rotation
  import eulr_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic signed [31:0] in_x_in,
  input  wire logic signed [31:0] in_y_in,
  input  wire logic signed [31:0] in_z_in,
  input  wire logic        [15:0] in_angle_x,
  input  wire logic        [15:0] in_angle_y,
  input  wire logic        [15:0] in_angle_z,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [31:0] out_x_out,
  output      logic signed [31:0] out_y_out,
  output      logic signed [31:0] out_z_out,
  output      logic               out_saturated
);

  localparam int NSTAGES = 15;
  localparam int CEND    = CORDIC_STAGES;
  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  logic en;
  logic [NSTAGES-1:0] vld_r;

  assign en        = !vld_r[NSTAGES-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[NSTAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGES-2:0], in_valid};
    end
  end

  // angle setup
  logic [15:0] ang [3];
  assign ang[0] = in_angle_x;
  assign ang[1] = in_angle_y;
  assign ang[2] = in_angle_z;

  cordic_t cs_r [CEND+1][3];
  quad_t   q_r  [CEND+1][3];
  point_t  pt_r [CEND+1];

  for (genvar k = 0; k < 3; k++) begin : g_setup
    logic [31:0] p;
    quad_t       q;
    cordic_t     c0;
    always_comb begin
      p    = (32'(ang[k]) & AMASK) << (32 - ANGLE_BITS);
      q    = quad_t'((p + 32'h20000000) >> 30);
      c0.x = GAIN_INV;
      c0.y = '0;
      c0.z = coord_t'(p - {q, 30'd0});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cs_r[0][k] <= c0;
        q_r[0][k]  <= q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r[0] <= '{x: in_x_in, y: in_y_in, z: in_z_in};
    end
  end

  // cordic stages
  for (genvar s = 1; s <= CEND; s++) begin : g_cordic
    for (genvar k = 0; k < 3; k++) begin : g_unit
      always_ff @(posedge clk) begin
        if (en) begin
          cs_r[s][k] <= cordic_group(cs_r[s-1][k], (s - 1) * ITERS_PER_STAGE);
          q_r[s][k]  <= q_r[s-1][k];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pt_r[s] <= pt_r[s-1];
      end
    end
  end

  // quadrant fold and rotation stages
  trig_t  tx_r, ty_r, tz_r;
  trig_t  tx9_r, ty9_r, tx10_r, ty10_r, tx11_r, tx12_r;
  point_t p8_r;
  coord_t z9_r, z10_r, y11_r, y12_r;
  prod_t  zp0_r, zp1_r, zp2_r, zp3_r;
  prod_t  yp0_r, yp1_r, yp2_r, yp3_r;
  prod_t  xp0_r, xp1_r, xp2_r, xp3_r;
  coord_t x10_r, y10_r, x12_r, z12_r;
  logic   sat10_r, sat11_r, sat12_r, sat13_r;
  coord_t x13_r;
  coord_t x_out_r, y_out_r, z_out_r;
  logic   sat_out_r;
  mix_t   mz0, mz1, my0, my1, mx0, mx1;

  always_comb begin
    mz0 = round_sat(psum_t'(zp0_r), -psum_t'(zp1_r));
    mz1 = round_sat(psum_t'(zp2_r), psum_t'(zp3_r));
    my0 = round_sat(psum_t'(yp0_r), psum_t'(yp1_r));
    my1 = round_sat(-psum_t'(yp2_r), psum_t'(yp3_r));
    mx0 = round_sat(psum_t'(xp0_r), -psum_t'(xp1_r));
    mx1 = round_sat(psum_t'(xp2_r), psum_t'(xp3_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 8: fold
      tx_r <= quad_map(cs_r[CEND][0], q_r[CEND][0]);
      ty_r <= quad_map(cs_r[CEND][1], q_r[CEND][1]);
      tz_r <= quad_map(cs_r[CEND][2], q_r[CEND][2]);
      p8_r <= pt_r[CEND];
      // stage 9: z products
      zp0_r <= p8_r.x * tz_r.c;
      zp1_r <= p8_r.y * tz_r.s;
      zp2_r <= p8_r.x * tz_r.s;
      zp3_r <= p8_r.y * tz_r.c;
      z9_r  <= p8_r.z;
      tx9_r <= tx_r;
      ty9_r <= ty_r;
      // stage 10: z rotate
      x10_r   <= mz0.v;
      y10_r   <= mz1.v;
      sat10_r <= mz0.sat | mz1.sat;
      z10_r   <= z9_r;
      tx10_r  <= tx9_r;
      ty10_r  <= ty9_r;
      // stage 11: y products
      yp0_r   <= x10_r * ty10_r.c;
      yp1_r   <= z10_r * ty10_r.s;
      yp2_r   <= x10_r * ty10_r.s;
      yp3_r   <= z10_r * ty10_r.c;
      y11_r   <= y10_r;
      sat11_r <= sat10_r;
      tx11_r  <= tx10_r;
      // stage 12: y rotate
      x12_r   <= my0.v;
      z12_r   <= my1.v;
      sat12_r <= sat11_r | my0.sat | my1.sat;
      y12_r   <= y11_r;
      tx12_r  <= tx11_r;
      // stage 13: x products
      xp0_r   <= y12_r * tx12_r.c;
      xp1_r   <= z12_r * tx12_r.s;
      xp2_r   <= y12_r * tx12_r.s;
      xp3_r   <= z12_r * tx12_r.c;
      x13_r   <= x12_r;
      sat13_r <= sat12_r;
      // stage 14: x rotate
      x_out_r   <= x13_r;
      y_out_r   <= mx0.v;
      z_out_r   <= mx1.v;
      sat_out_r <= sat13_r | mx0.sat | mx1.sat;
    end
  end

  assign out_x_out     = x_out_r;
  assign out_y_out     = y_out_r;
  assign out_z_out     = z_out_r;
  assign out_saturated = sat_out_r;

endmodule
`default_nettype wire
